// ===== src/mbp_pkg.sv =====
// Package of the MIDI byte stream parser: byte classes, result kinds, queue entry and
// result record types, and the queue depth. Used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mbp_pkg;

   // queue between the classifier and the executor
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] STATUS_NONE  = 8'h00;
   localparam logic [7:0] STATUS_SYSEX = 8'hF0;
   localparam logic [7:0] BYTE_EOX     = 8'hF7;
   localparam logic [7:0] OP_MASK      = 8'hF0;
   localparam logic [7:0] OP_NOTE_OFF  = 8'h80;
   localparam logic [7:0] OP_NOTE_ON   = 8'h90;
   localparam logic [7:0] OP_PROGRAM   = 8'hC0;
   localparam logic [7:0] OP_PRESSURE  = 8'hD0;
   localparam logic [6:0] VEL_DEFAULT  = 7'h40;
   localparam logic [4:0] CHAN_ALL     = 5'd16;

   typedef enum logic [2:0] {
      CLS_STATUS   = 3'd0,   // channel status or sysex start
      CLS_EOX      = 3'd1,
      CLS_REALTIME = 3'd2,
      CLS_SYSCOM   = 3'd3,
      CLS_DATA     = 3'd4
   } byte_class_type;

   typedef enum logic [2:0] {
      KIND_CHANNEL   = 3'd0,
      KIND_REALTIME  = 3'd1,
      KIND_LONE_EOX  = 3'd2,
      KIND_SYSCOM    = 3'd3,
      KIND_SYSEX_DAT = 3'd4,
      KIND_SYSEX_END = 3'd5,
      KIND_STRAY     = 3'd6
   } rsp_kind_type;

   typedef struct packed {
      byte_class_type cls;
      logic [7:0]     data_byte;
   } entry_type;

   typedef struct packed {
      rsp_kind_type kind;
      logic [7:0]   opcode;
      logic [4:0]   channel;
      logic [6:0]   first_value;
      logic [6:0]   second_value;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/mbp_front.sv =====
// Front end of the MIDI byte stream parser: takes input items and classifies each byte.
// Depends on mbp_pkg; feeds mbp_queue.
`timescale 1ns / 1ps
`default_nettype none

module mbp_front
   import mbp_pkg::*;
(
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       queue_full,
   output logic            push,
   output entry_type       push_entry
);

   byte_class_type cls;
   logic [7:0]     b;

   assign b = req_tdata;

   always_comb begin
      if (!b[7]) begin
         cls = CLS_DATA;
      end else if (b[7:4] != 4'hF || b == STATUS_SYSEX) begin
         cls = CLS_STATUS;
      end else if (b == BYTE_EOX) begin
         cls = CLS_EOX;
      end else begin
         case (b[3:0])
            4'h8, 4'hA, 4'hB, 4'hC, 4'hE, 4'hF: cls = CLS_REALTIME;
            default:                            cls = CLS_SYSCOM;
         endcase
      end
   end

   assign req_tready           = !queue_full;
   assign push                 = req_tvalid && !queue_full;
   assign push_entry.cls       = cls;
   assign push_entry.data_byte = b;

endmodule

`default_nettype wire

// ===== src/mbp_queue.sv =====
// Short queue of classified bytes between the front end and the executor.
// Depends on mbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbp_queue
   import mbp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output logic           full,
   output logic           empty,
   output entry_type      head
);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff,  count_in;

   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== src/mbp_back.sv =====
// Executor of the MIDI byte stream parser: keeps running status, data count and held byte,
// builds results and holds them in the output register. Depends on mbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbp_back
   import mbp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      empty,
   input  wire entry_type head,
   output logic           pop,
   output logic           rsp_tvalid,
   input  wire logic      rsp_tready,
   output rsp_type        rsp
);

   logic [7:0] status_ff, status_in;
   logic       count_ff,  count_in;
   logic [6:0] held_ff,   held_in;
   logic       valid_ff,  valid_in;
   rsp_type    rsp_ff,    rsp_in;

   rsp_type    res;
   logic       has_res;
   logic       in_sysex;
   logic       in_channel;
   logic       one_byte;
   logic [7:0] op;
   logic [6:0] b7;

   assign in_sysex   = (status_ff == STATUS_SYSEX);
   assign in_channel = status_ff[7] && (status_ff[7:4] != 4'hF);
   assign op         = status_ff & OP_MASK;
   assign one_byte   = (op == OP_PROGRAM) || (op == OP_PRESSURE);
   assign b7         = head.data_byte[6:0];

   assign pop = !empty && (!valid_ff || rsp_tready);

   always_comb begin
      status_in        = status_ff;
      count_in         = count_ff;
      held_in          = held_ff;
      has_res          = 1'b0;
      res.kind         = KIND_STRAY;
      res.opcode       = head.data_byte;
      res.channel      = CHAN_ALL;
      res.first_value  = '0;
      res.second_value = '0;
      unique case (head.cls)
         CLS_STATUS: begin
            status_in = head.data_byte;
            count_in  = 1'b0;
         end
         CLS_EOX: begin
            has_res    = 1'b1;
            res.kind   = in_sysex ? KIND_SYSEX_END : KIND_LONE_EOX;
            res.opcode = in_sysex ? STATUS_SYSEX : BYTE_EOX;
            status_in  = STATUS_NONE;
            count_in   = 1'b0;
         end
         CLS_REALTIME: begin
            has_res  = 1'b1;
            res.kind = KIND_REALTIME;
         end
         CLS_SYSCOM: begin
            has_res   = 1'b1;
            res.kind  = KIND_SYSCOM;
            status_in = STATUS_NONE;
            count_in  = 1'b0;
         end
         CLS_DATA: begin
            if (in_sysex) begin
               has_res         = 1'b1;
               res.kind        = KIND_SYSEX_DAT;
               res.opcode      = STATUS_SYSEX;
               res.first_value = b7;
            end else if (!in_channel) begin
               has_res         = 1'b1;
               res.kind        = KIND_STRAY;
               res.opcode      = '0;
               res.first_value = b7;
            end else if (!one_byte && !count_ff) begin
               // hold the first of two data bytes
               held_in  = b7;
               count_in = 1'b1;
            end else begin
               has_res          = 1'b1;
               count_in         = 1'b0;
               res.kind         = KIND_CHANNEL;
               res.opcode       = op;
               res.channel      = {1'b0, status_ff[3:0]};
               res.first_value  = one_byte ? b7 : held_ff;
               res.second_value = one_byte ? 7'd0 : b7;
               // note on with zero velocity reads as note off
               if (op == OP_NOTE_ON && res.second_value == 7'd0) begin
                  res.opcode       = OP_NOTE_OFF;
                  res.second_value = VEL_DEFAULT;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (pop && has_res) begin
         valid_in = 1'b1;
         rsp_in   = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= STATUS_NONE;
         count_ff  <= 1'b0;
         held_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            status_ff <= status_in;
            count_ff  <= count_in;
            held_ff   <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp        = rsp_ff;

endmodule

`default_nettype wire

// ===== src/midi_byte_stream_parser.sv =====
// MIDI byte stream parser with running status: top level.
// Instantiates mbp_front, mbp_queue and mbp_back; depends on mbp_pkg.
//
// Usage:
//  - req channel: one raw MIDI byte per item in req_tdata[7:0].
//  - rsp channel: zero or one result per byte. rsp_tuser[2:0] carries the kind
//    (channel message, realtime, lone EOX, system common, sysex data, sysex end,
//    stray data byte); rsp_tdata carries opcode, channel and both data bytes.
//  - Channel status and sysex start bytes and the first data byte of a two-byte
//    channel message give no result; the result comes with the completing byte.
//  - Path: an accepted byte is written to a queue slot, and its result is
//    then registered in the output register once the executor takes it.
//  - Throughput: one byte per cycle while rsp_tready is high. The classifier and the
//    executor are parted by a four-entry queue and the executor by the output
//    register, so a new byte is taken while a result still waits.
//  - Stall: when the receiver holds rsp_tready low the result holds, the
//    executor stops, the queue fills, and req_tready falls once it is full.
//  - Reset (synchronous, active high): clear running status, data count,
//    held byte, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module midi_byte_stream_parser
   import mbp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] opcode, [12:8] channel,
                                         // [19:13] first_value, [26:20] second_value,
                                         // [31:27] zero
   output logic [2:0]       rsp_tuser    // [2:0] kind
);

   logic      queue_full;
   logic      queue_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;
   rsp_type   rsp;

   // classify incoming bytes
   mbp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouple front and back
   mbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   // advance running status and build results
   mbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (queue_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tdata = {5'd0, rsp.second_value, rsp.first_value, rsp.channel, rsp.opcode};

endmodule

`default_nettype wire
